@@ sv/grid_next_hop_with_obstacle_defines.svh @@
// Assertion macros shared by the next-hop router RTL.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef GRID_NEXT_HOP_WITH_OBSTACLE_DEFINES_SVH
`define GRID_NEXT_HOP_WITH_OBSTACLE_DEFINES_SVH

// Implication checked on every rising edge, switched off while reset is asserted.
`define GNHO_ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("gnho assertion failed");

// Condition that must never be true outside reset.
`define GNHO_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("gnho forbidden condition seen");

`endif

@@ sv/gnho_pkg.sv @@
// Shared types, constants and helper functions for the grid next-hop router.
// No dependencies; imported by every module of the block.
package gnho_pkg;

	localparam int CELL_W  = 4;
	localparam int CELLS   = 2 ** CELL_W;
	localparam int COORD_W = 4;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int POS_W   = COORD_W + 2;

	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
	} coord_t;

	// Compass region codes of an offset; a zero offset falls into up-left.
	localparam logic [2:0] REG_UL = 3'd0;
	localparam logic [2:0] REG_U  = 3'd1;
	localparam logic [2:0] REG_UR = 3'd2;
	localparam logic [2:0] REG_R  = 3'd3;
	localparam logic [2:0] REG_DR = 3'd4;
	localparam logic [2:0] REG_D  = 3'd5;
	localparam logic [2:0] REG_DL = 3'd6;
	localparam logic [2:0] REG_L  = 3'd7;

	// Bit b of entry g is set when an obstacle in region b blocks a goal in region g.
	localparam logic [7:0] CONFLICT_MASK [8] = '{
		8'h83, 8'h02, 8'h0E, 8'h08, 8'h38, 8'h20, 8'hE0, 8'h80
	};

	function automatic logic [2:0] compass(input logic signed [DIFF_W-1:0] dx,
		input logic signed [DIFF_W-1:0] dy);
		logic [2:0] code;
		if (dy < 0) begin
			code = (dx < 0) ? REG_UL : ((dx == 0) ? REG_U : REG_UR);
		end else if (dy > 0) begin
			code = (dx > 0) ? REG_DR : ((dx == 0) ? REG_D : REG_DL);
		end else if (dx > 0) begin
			code = REG_R;
		end else if (dx < 0) begin
			code = REG_L;
		end else begin
			code = REG_UL;
		end
		return code;
	endfunction

	function automatic logic [COORD_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
		logic signed [DIFF_W-1:0] a;
		a = (v < 0) ? -v : v;
		return a[COORD_W-1:0];
	endfunction

	function automatic logic signed [1:0] sgn(input logic signed [DIFF_W-1:0] v);
		logic signed [1:0] s;
		s = (v > 0) ? 2'sd1 : ((v < 0) ? -2'sd1 : 2'sd0);
		return s;
	endfunction

endpackage

@@ sv/gnho_decode.sv @@
// Splits a cell number into row and column through a constant lookup table.
// Depends on gnho_pkg.
module gnho_decode #(
	parameter int GRID_SIDE = 4
) (
	input  logic [gnho_pkg::CELL_W-1:0] cell_num,
	output gnho_pkg::coord_t            pos
);
	import gnho_pkg::*;

	logic [COORD_W-1:0] row_tab [CELLS];
	logic [COORD_W-1:0] col_tab [CELLS];

	// The table is folded at elaboration, so no divider is built.
	for (genvar i = 0; i < CELLS; i++) begin : g_tab
		assign row_tab[i] = COORD_W'(i / GRID_SIDE);
		assign col_tab[i] = COORD_W'(i % GRID_SIDE);
	end

	assign pos.row = row_tab[cell_num];
	assign pos.col = col_tab[cell_num];

endmodule

@@ sv/gnho_route.sv @@
// Next-hop decision for one beat: hold, direct step, obstacle sidestep or ordinary step.
// Depends on gnho_pkg.
module gnho_route #(
	parameter int GRID_SIDE = 4
) (
	input  gnho_pkg::coord_t            cur,
	input  gnho_pkg::coord_t            goal,
	input  gnho_pkg::coord_t            obs,
	output logic [gnho_pkg::CELL_W-1:0] next_cell
);
	import gnho_pkg::*;

	logic signed [DIFF_W-1:0] dx, dy, bx, by;
	logic signed [1:0]        mx, my;
	logic [COORD_W-1:0]       adx, ady, abx, aby;
	logic                     conflict;
	logic signed [POS_W-1:0]  nx, ny;

	always_comb begin
		dx = $signed({1'b0, goal.col}) - $signed({1'b0, cur.col});
		dy = $signed({1'b0, goal.row}) - $signed({1'b0, cur.row});
		bx = $signed({1'b0, obs.col}) - $signed({1'b0, cur.col});
		by = $signed({1'b0, obs.row}) - $signed({1'b0, cur.row});
		mx = sgn(dx);
		my = sgn(dy);
		adx = mag(dx);
		ady = mag(dy);
		abx = mag(bx);
		aby = mag(by);
		conflict = CONFLICT_MASK[compass(dx, dy)][compass(bx, by)];
		nx = $signed({2'b00, cur.col});
		ny = $signed({2'b00, cur.row});

		if (goal == obs) begin
			// Goal is occupied: hold position.
		end else if (adx == COORD_W'(1) && dy == 0) begin
			nx = nx + POS_W'(dx);
		end else if (ady == COORD_W'(1) && dx == 0) begin
			ny = ny + POS_W'(dy);
		end else if (conflict && abx == COORD_W'(1) && aby == COORD_W'(1)) begin
			if (adx > ady) begin
				nx = nx + POS_W'(mx);
			end else begin
				ny = ny + POS_W'(my);
			end
		end else if (conflict && abx == COORD_W'(1) && aby == '0) begin
			// Blocked along the row: move off it vertically, toward the goal row if it differs, else up unless on the top row.
			if (my != 0) begin
				ny = ny + POS_W'(my);
			end else if (cur.row == '0) begin
				ny = ny + POS_W'(1);
			end else begin
				ny = ny - POS_W'(1);
			end
		end else if (conflict && abx == '0 && aby == COORD_W'(1)) begin
			if (mx != 0) begin
				nx = nx + POS_W'(mx);
			end else if (cur.col == '0) begin
				nx = nx + POS_W'(1);
			end else begin
				nx = nx - POS_W'(1);
			end
		end else if (dx != 0 && dy != 0) begin
			if (adx <= ady) begin
				nx = nx + POS_W'(mx);
			end else begin
				ny = ny + POS_W'(my);
			end
		end else if (dx == 0) begin
			ny = ny + POS_W'(my);
		end else begin
			nx = nx + POS_W'(mx);
		end
	end

	// Only the low bits of the cell number are kept, as the encoding wraps.
	assign next_cell = CELL_W'(ny * GRID_SIDE + nx);

endmodule

@@ sv/grid_next_hop_with_obstacle.sv @@
// Grid next-hop router with one obstacle on a GRID_SIDE by GRID_SIDE grid.
//
// Input channel: in_valid/in_ready carry current_cell, goal_cell and
// obstacle_cell, each a row-major cell number. Output channel:
// out_valid/out_ready carry next_cell, one result beat per input beat,
// in order.
// out_valid rises once the beat has passed the input register, where the
// routing logic settles, and has been captured in the result register; the
// result beat is taken at an edge where out_ready is high.
// Throughput is one beat per cycle while the receiver keeps out_ready high.
// If the receiver stalls, the result register holds its beat and the input
// register still takes one more beat; after that in_ready drops until the
// result is taken. Asynchronous reset empties both registers, so no result
// is presented until a new beat arrives.
// Depends on gnho_pkg, gnho_decode, gnho_route and the defines header.
`include "grid_next_hop_with_obstacle_defines.svh"

module grid_next_hop_with_obstacle #(
	parameter int GRID_SIDE = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [gnho_pkg::CELL_W-1:0] current_cell,
	input  logic [gnho_pkg::CELL_W-1:0] goal_cell,
	input  logic [gnho_pkg::CELL_W-1:0] obstacle_cell,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [gnho_pkg::CELL_W-1:0] next_cell
);
	import gnho_pkg::*;

	logic                valid_s1, valid_s2;
	logic [CELL_W-1:0]   current_s1, goal_s1, obstacle_s1;
	logic [CELL_W-1:0]   next_cell_s2;
	logic [CELL_W-1:0]   route_cell;
	coord_t              cur_pos, goal_pos, obs_pos;
	logic                load_s2, load_s1;

	assign load_s2  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || load_s2;
	assign load_s1  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (!valid_s2 || out_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			current_s1  <= current_cell;
			goal_s1     <= goal_cell;
			obstacle_s1 <= obstacle_cell;
		end
		if (load_s2) begin
			next_cell_s2 <= route_cell;
		end
	end

	gnho_decode #(.GRID_SIDE(GRID_SIDE)) u_dec_cur (.cell_num(current_s1), .pos(cur_pos));
	gnho_decode #(.GRID_SIDE(GRID_SIDE)) u_dec_goal (.cell_num(goal_s1), .pos(goal_pos));
	gnho_decode #(.GRID_SIDE(GRID_SIDE)) u_dec_obs (.cell_num(obstacle_s1), .pos(obs_pos));

	gnho_route #(.GRID_SIDE(GRID_SIDE)) u_route (
		.cur       (cur_pos),
		.goal      (goal_pos),
		.obs       (obs_pos),
		.next_cell (route_cell)
	);

	assign out_valid = valid_s2;
	assign next_cell = next_cell_s2;

	`GNHO_ASSERT_CLK(a_advance_fills_result, clk, arst_n, load_s2 |=> valid_s2)
	`GNHO_ASSERT_CLK(a_blocked_goal_holds, clk, arst_n,
		(load_s2 && goal_s1 == obstacle_s1) |=> (next_cell_s2 == $past(current_s1)))
	`GNHO_ASSERT_CLK(a_stall_keeps_stage1, clk, arst_n,
		(valid_s1 && valid_s2 && !out_ready) |=> (valid_s1 && $stable(current_s1)))
	`GNHO_ASSERT_NEVER(a_no_overwrite, clk, arst_n, load_s1 && valid_s1 && !load_s2)

endmodule
